### rtl/att_pkg.sv
// Shared types, constants and character classing for the assembly text tokenizer.
package att_pkg;

  // Source size limit and derived offset width
  localparam int unsigned MAX_SOURCE_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);
  localparam int unsigned MAX_RESULTS = 4;

  // Queue depths
  localparam int unsigned ITEMQ_DEPTH = 4;
  localparam int unsigned TOKQ_DEPTH = 8;

  // Token kinds
  localparam logic [4:0] KIND_IDENT  = 5'd0;
  localparam logic [4:0] KIND_REG    = 5'd1;
  localparam logic [4:0] KIND_OPREF  = 5'd2;
  localparam logic [4:0] KIND_NUMBER = 5'd3;
  localparam logic [4:0] KIND_DOT    = 5'd4;
  localparam logic [4:0] KIND_COMMA  = 5'd5;
  localparam logic [4:0] KIND_SEMI   = 5'd6;
  localparam logic [4:0] KIND_LBRACK = 5'd7;
  localparam logic [4:0] KIND_RBRACK = 5'd8;
  localparam logic [4:0] KIND_LBRACE = 5'd9;
  localparam logic [4:0] KIND_RBRACE = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd11;
  localparam logic [4:0] KIND_MINUS  = 5'd12;
  localparam logic [4:0] KIND_AT     = 5'd13;
  localparam logic [4:0] KIND_BANG   = 5'd14;
  localparam logic [4:0] KIND_ERROR  = 5'd15;
  localparam logic [4:0] KIND_EOF    = 5'd16;

  // Characters the lexer tests for
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_UP_E    = 8'h45;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_item;
    logic       no_char;
  } att_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } att_token_t;

  typedef att_token_t [MAX_RESULTS-1:0] att_tok_group_t;

  typedef struct packed {
    logic       is_space;
    logic       is_dec;
    logic       is_start;
    logic       is_hex;
    logic       is_punct;
    logic [4:0] punct;
  } char_class_t;

  typedef struct packed {
    att_item_t   item;
    char_class_t cls;
  } att_citem_t;

  // Character class lookup
  function automatic char_class_t classify(logic [7:0] c);
    char_class_t r;
    r = '0;
    r.is_space = (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B});
    r.is_dec   = (c inside {[8'h30:8'h39]});
    r.is_start = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
    r.is_hex   = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    r.is_punct = 1'b1;
    case (c)
      8'h2E:   r.punct = KIND_DOT;
      8'h2C:   r.punct = KIND_COMMA;
      8'h3B:   r.punct = KIND_SEMI;
      8'h5B:   r.punct = KIND_LBRACK;
      8'h5D:   r.punct = KIND_RBRACK;
      8'h7B:   r.punct = KIND_LBRACE;
      8'h7D:   r.punct = KIND_RBRACE;
      8'h2B:   r.punct = KIND_PLUS;
      8'h40:   r.punct = KIND_AT;
      8'h21:   r.punct = KIND_BANG;
      default: r.is_punct = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/assembly_text_tokenizer.sv
// Top level of the assembly text tokenizer: front end, item queue, lexer, token queue.
//
//   channel  | direction | payload      | handshake
//   in       | input     | att_item_t   | in_valid_i / in_stall_o
//   out      | output    | att_token_t  | out_valid_o / out_stall_i
//
// One source byte is taken per cycle when not stalled; the lexer retires one queued
// item a cycle and writes its zero to four tokens into the token queue at once.
// The lexer waits while the token queue has fewer than four free entries, so without
// output stalls it sustains one item a cycle while items average one token or less.
// Reset clears all lexer state and both queues; no clearing pass is needed.
// in_stall_o rises only when the four-entry item queue is full.
module assembly_text_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  att_pkg::att_item_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output att_pkg::att_token_t out_data_o,
  input  logic                out_stall_i
);
  import att_pkg::*;

  logic           q_valid, q_pop, room;
  att_citem_t     q_data;
  logic [2:0]     push_n;
  att_tok_group_t push_toks;

  att_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  att_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .room_i      (room),
    .push_n_o    (push_n),
    .push_toks_o (push_toks)
  );

  att_tok_fifo u_tok_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_toks_i (push_toks),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### rtl/att_front.sv
// Front end: accepts source bytes, classifies them and queues them for the lexer.
module att_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  att_pkg::att_item_t     in_data_i,
  output logic                   in_stall_o,
  output logic                   q_valid_o,
  output att_pkg::att_citem_t    q_data_o,
  input  logic                   q_pop_i
);
  import att_pkg::*;

  localparam int unsigned PW = $clog2(ITEMQ_DEPTH);

  att_citem_t            mem_q [ITEMQ_DEPTH];
  logic [PW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [PW:0]           count_q, count_d;
  logic                  push;

  assign in_stall_o = (count_q == (PW+1)'(ITEMQ_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = mem_q[head_q];

  // Pointer and fill bookkeeping
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      tail_d = tail_q + PW'(1);
    end
    if (q_pop_i) begin
      head_d = head_q + PW'(1);
    end
    count_d = count_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Classified item storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[tail_q].item <= in_data_i;
      mem_q[tail_q].cls  <= classify(in_data_i.ch);
    end
  end

endmodule

### rtl/att_lexer.sv
// Back end: lexer state machine, up to four tokens per item.
module att_lexer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  att_pkg::att_citem_t     q_data_i,
  output logic                    q_pop_o,
  input  logic                    room_i,
  output logic [2:0]              push_n_o,
  output att_pkg::att_tok_group_t push_toks_o
);
  import att_pkg::*;

  localparam logic [4:0] M_WS        = 5'd0;
  localparam logic [4:0] M_SLASH     = 5'd1;
  localparam logic [4:0] M_LINE      = 5'd2;
  localparam logic [4:0] M_BLOCK0    = 5'd3;
  localparam logic [4:0] M_BLOCKSTAR = 5'd4;
  localparam logic [4:0] M_MINUS     = 5'd5;
  localparam logic [4:0] M_ZERO      = 5'd6;
  localparam logic [4:0] M_INT       = 5'd7;
  localparam logic [4:0] M_FRAC      = 5'd8;
  localparam logic [4:0] M_EXP0      = 5'd9;
  localparam logic [4:0] M_EXPD      = 5'd10;
  localparam logic [4:0] M_HEX       = 5'd11;
  localparam logic [4:0] M_TAIL      = 5'd12;
  localparam logic [4:0] M_IDENT     = 5'd13;
  localparam logic [4:0] M_IDCOLON1  = 5'd14;
  localparam logic [4:0] M_IDCOLON2  = 5'd15;
  localparam logic [4:0] M_PCT       = 5'd16;
  localparam logic [4:0] M_PCTPCT    = 5'd17;
  localparam logic [4:0] M_PCTNUM    = 5'd18;
  localparam logic [4:0] M_PCTREG    = 5'd19;
  localparam logic [4:0] M_DOL       = 5'd20;
  localparam logic [4:0] M_DOLNUM    = 5'd21;

  localparam pos_t ONE = POS_W'(1);
  localparam pos_t TWO = POS_W'(2);

  logic [4:0]  mode_q, mode_d;
  pos_t        origin_q, origin_d, pos_q, pos_d;
  logic [7:0]  hbyte_q, hbyte_d;
  logic        held_q, held_d, hex_q, hex_d, letters_q, letters_d, halted_q, halted_d;

  logic        do_start, relex, cont, num_end;
  logic [7:0]  c, sc;
  pos_t        sp, cp, fp;
  char_class_t cl, scl;
  logic [2:0]  n;
  att_tok_group_t toks;
  logic [4:0]  num_kind;

  // Offset and length, saturated to 16 bits
  function automatic att_token_t mk_tok(logic [4:0] kind, pos_t start, pos_t stop);
    att_token_t t;
    pos_t       len;
    len = (stop >= start) ? (stop - start) : '0;
    t.token_kind   = kind;
    t.token_start  = (32'(start) > 32'd65535) ? 16'hFFFF : 16'(start);
    t.token_length = (32'(len) > 32'd65535) ? 16'hFFFF : 16'(len);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  assign c    = q_data_i.item.ch;
  assign cl   = q_data_i.cls;
  assign cont = cl.is_start | cl.is_dec;

  // One item: byte step, optional re-lex of a trailing comment byte, end of source
  always_comb begin
    mode_d    = mode_q;
    origin_d  = origin_q;
    pos_d     = pos_q;
    hbyte_d   = hbyte_q;
    held_d    = held_q;
    hex_d     = hex_q;
    letters_d = letters_q;
    halted_d  = halted_q;
    n         = '0;
    toks      = '0;
    do_start  = 1'b0;
    relex     = 1'b0;
    num_end   = 1'b0;
    sc        = c;
    sp        = pos_q;
    cp        = '0;
    fp        = '0;
    scl       = cl;
    num_kind  = (letters_q && !hex_q) ? KIND_IDENT : KIND_NUMBER;
    q_pop_o   = q_valid_i && room_i;

    if (q_pop_o && !q_data_i.item.no_char && !halted_q &&
        (pos_q < POS_W'(MAX_SOURCE_BYTES))) begin
      case (mode_q)
        M_WS: begin
          do_start = 1'b1;
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = M_LINE;
          end else if (c == CH_STAR) begin
            mode_d = M_BLOCK0;
            held_d = 1'b0;
          end else begin
            toks[n[1:0]] = mk_tok(KIND_ERROR, origin_q, origin_q + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = origin_q + ONE;
            mode_d   = M_WS;
          end
        end
        M_LINE: begin
          if (c == CH_NL) mode_d = M_WS;
        end
        M_BLOCK0, M_BLOCKSTAR: begin
          if (mode_q == M_BLOCKSTAR && c == CH_SLASH) begin
            mode_d = M_WS;
            held_d = 1'b0;
          end else begin
            mode_d  = (c == CH_STAR) ? M_BLOCKSTAR : M_BLOCK0;
            hbyte_d = c;
            held_d  = 1'b1;
          end
        end
        M_MINUS: begin
          if (cl.is_dec) begin
            mode_d = (c == CH_ZERO) ? M_ZERO : M_INT;
          end else begin
            toks[n[1:0]] = mk_tok(KIND_MINUS, origin_q, origin_q + ONE);
            n = n + 3'd1;
            mode_d   = M_WS;
            do_start = 1'b1;
          end
        end
        M_ZERO, M_INT: begin
          if (mode_q == M_ZERO && (c == CH_LOW_X || c == CH_UP_X)) begin
            hex_d  = 1'b1;
            mode_d = M_HEX;
          end else if (cl.is_dec) begin
            mode_d = M_INT;
          end else if (c == CH_DOT) begin
            mode_d = M_FRAC;
          end else if (c == CH_LOW_E || c == CH_UP_E) begin
            mode_d = M_EXP0;
          end else begin
            num_end = 1'b1;
          end
        end
        M_FRAC: begin
          if (c == CH_LOW_E || c == CH_UP_E) begin
            mode_d = M_EXP0;
          end else if (!cl.is_dec) begin
            num_end = 1'b1;
          end
        end
        M_EXP0: begin
          if (c == CH_PLUS || c == CH_MINUS || cl.is_dec) begin
            mode_d = M_EXPD;
          end else begin
            num_end = 1'b1;
          end
        end
        M_EXPD: begin
          if (!cl.is_dec) num_end = 1'b1;
        end
        M_HEX: begin
          if (!cl.is_hex) num_end = 1'b1;
        end
        M_TAIL: begin
          num_end = 1'b1;
        end
        M_IDENT: begin
          if (c == CH_COLON) begin
            mode_d = M_IDCOLON1;
          end else if (!cont) begin
            toks[n[1:0]] = mk_tok(KIND_IDENT, origin_q, pos_q);
            n = n + 3'd1;
            mode_d   = M_WS;
            do_start = 1'b1;
          end
        end
        M_IDCOLON1, M_IDCOLON2: begin
          if (mode_q == M_IDCOLON1 && c == CH_COLON) begin
            mode_d = M_IDCOLON2;
          end else if (mode_q == M_IDCOLON2 && cont) begin
            mode_d = M_IDENT;
          end else begin
            // failed double colon: identifier up to the colon, colon is an error
            cp = pos_q - ((mode_q == M_IDCOLON1) ? ONE : TWO);
            toks[n[1:0]] = mk_tok(KIND_IDENT, origin_q, cp);
            n = n + 3'd1;
            toks[n[1:0]] = mk_tok(KIND_ERROR, cp, cp + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = cp + ONE;
            mode_d   = M_WS;
          end
        end
        M_PCT: begin
          if (c == CH_PERCENT) begin
            mode_d = M_PCTPCT;
          end else if (cl.is_dec) begin
            mode_d = M_PCTNUM;
          end else if (cl.is_start) begin
            mode_d = M_PCTREG;
          end else begin
            toks[n[1:0]] = mk_tok(KIND_ERROR, origin_q, origin_q + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = origin_q + ONE;
            mode_d   = M_WS;
          end
        end
        M_PCTPCT, M_PCTREG: begin
          if (!(cont || (mode_q == M_PCTPCT && c == CH_DOT))) begin
            toks[n[1:0]] = mk_tok(KIND_REG, origin_q, pos_q);
            n = n + 3'd1;
            mode_d   = M_WS;
            do_start = 1'b1;
          end
        end
        M_PCTNUM, M_DOLNUM: begin
          if (!cl.is_dec) begin
            toks[n[1:0]] = mk_tok(KIND_OPREF, origin_q, pos_q);
            n = n + 3'd1;
            mode_d   = M_WS;
            do_start = 1'b1;
          end
        end
        M_DOL: begin
          if (cl.is_dec) begin
            mode_d = M_DOLNUM;
          end else begin
            toks[n[1:0]] = mk_tok(KIND_ERROR, origin_q, origin_q + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = origin_q + ONE;
            mode_d   = M_WS;
          end
        end
        default: begin
          mode_d   = M_WS;
          do_start = 1'b1;
        end
      endcase

      // number tail: letters and digits fold into the token, anything else ends it
      if (num_end) begin
        if (cont) begin
          letters_d = 1'b1;
          mode_d    = M_TAIL;
        end else begin
          toks[n[1:0]] = mk_tok(num_kind, origin_q, pos_q);
          n = n + 3'd1;
          mode_d   = M_WS;
          do_start = 1'b1;
        end
      end
      pos_d = pos_q + ONE;
    end

    // unterminated block comment: its last byte is lexed again on its own
    if (q_pop_o && q_data_i.item.final_item && !halted_d &&
        (mode_d == M_BLOCK0 || mode_d == M_BLOCKSTAR)) begin
      relex  = held_d;
      mode_d = M_WS;
      held_d = 1'b0;
    end
    if (relex) begin
      do_start = 1'b1;
      sc       = hbyte_d;
      sp       = pos_d - ONE;
      scl      = classify(hbyte_d);
    end

    // token start
    if (do_start) begin
      origin_d  = sp;
      hex_d     = 1'b0;
      letters_d = 1'b0;
      mode_d    = M_WS;
      if (scl.is_space) begin
        mode_d = M_WS;
      end else if (scl.is_punct) begin
        toks[n[1:0]] = mk_tok(scl.punct, sp, sp + ONE);
        n = n + 3'd1;
      end else if (sc == CH_SLASH) begin
        mode_d = M_SLASH;
      end else if (sc == CH_MINUS) begin
        mode_d = M_MINUS;
      end else if (scl.is_dec) begin
        mode_d = (sc == CH_ZERO) ? M_ZERO : M_INT;
      end else if (scl.is_start) begin
        mode_d = M_IDENT;
      end else if (sc == CH_PERCENT) begin
        mode_d = M_PCT;
      end else if (sc == CH_DOLLAR) begin
        mode_d = M_DOL;
      end else begin
        toks[n[1:0]] = mk_tok(KIND_ERROR, sp, sp + ONE);
        n = n + 3'd1;
        halted_d = 1'b1;
        origin_d = sp + ONE;
      end
    end

    // end of source: close the open token, then end-of-file
    if (q_pop_o && q_data_i.item.final_item) begin
      fp = pos_d;
      if (!halted_d) begin
        case (mode_d)
          M_SLASH, M_PCT, M_DOL: begin
            toks[n[1:0]] = mk_tok(KIND_ERROR, origin_d, origin_d + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = origin_d + ONE;
          end
          M_MINUS: begin
            toks[n[1:0]] = mk_tok(KIND_MINUS, origin_d, origin_d + ONE);
            n = n + 3'd1;
          end
          M_ZERO, M_INT, M_FRAC, M_EXP0, M_EXPD, M_HEX, M_TAIL: begin
            toks[n[1:0]] = mk_tok((letters_d && !hex_d) ? KIND_IDENT : KIND_NUMBER,
                                  origin_d, fp);
            n = n + 3'd1;
          end
          M_IDENT: begin
            toks[n[1:0]] = mk_tok(KIND_IDENT, origin_d, fp);
            n = n + 3'd1;
          end
          M_IDCOLON1, M_IDCOLON2: begin
            cp = fp - ((mode_d == M_IDCOLON1) ? ONE : TWO);
            toks[n[1:0]] = mk_tok(KIND_IDENT, origin_d, cp);
            n = n + 3'd1;
            toks[n[1:0]] = mk_tok(KIND_ERROR, cp, cp + ONE);
            n = n + 3'd1;
            halted_d = 1'b1;
            origin_d = cp + ONE;
          end
          M_PCTPCT, M_PCTREG: begin
            toks[n[1:0]] = mk_tok(KIND_REG, origin_d, fp);
            n = n + 3'd1;
          end
          M_PCTNUM, M_DOLNUM: begin
            toks[n[1:0]] = mk_tok(KIND_OPREF, origin_d, fp);
            n = n + 3'd1;
          end
          default: begin
          end
        endcase
      end
      toks[n[1:0]] = halted_d ? mk_tok(KIND_EOF, origin_d, origin_d) :
                                mk_tok(KIND_EOF, fp, fp);
      n = n + 3'd1;
      // back to reset state for the next source
      mode_d    = M_WS;
      origin_d  = '0;
      pos_d     = '0;
      hbyte_d   = '0;
      held_d    = 1'b0;
      hex_d     = 1'b0;
      letters_d = 1'b0;
      halted_d  = 1'b0;
    end

    if (n != 3'd0) begin
      toks[2'(n - 3'd1)].last_of_run = 1'b1;
    end
    push_n_o    = n;
    push_toks_o = toks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_WS;
      origin_q  <= '0;
      pos_q     <= '0;
      hbyte_q   <= '0;
      held_q    <= 1'b0;
      hex_q     <= 1'b0;
      letters_q <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      origin_q  <= origin_d;
      pos_q     <= pos_d;
      hbyte_q   <= hbyte_d;
      held_q    <= held_d;
      hex_q     <= hex_d;
      letters_q <= letters_d;
      halted_q  <= halted_d;
    end
  end

endmodule

### rtl/att_tok_fifo.sv
// Token queue: takes up to four tokens a cycle, hands out one while out_stall_i is low.
module att_tok_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2:0]              push_n_i,
  input  att_pkg::att_tok_group_t push_toks_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  output att_pkg::att_token_t     out_data_o,
  input  logic                    out_stall_i
);
  import att_pkg::*;

  localparam int unsigned PW = $clog2(TOKQ_DEPTH);

  att_token_t    mem_q [TOKQ_DEPTH];
  logic [PW-1:0] head_q, tail_q;
  logic [PW:0]   count_q;
  logic          pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= (PW+1)'(TOKQ_DEPTH - MAX_RESULTS));

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + PW'(pop);
      tail_q  <= tail_q + PW'(push_n_i);
      count_q <= count_q + (PW+1)'(push_n_i) - (PW+1)'(pop);
    end
  end

  // Token storage, one write port per result slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (3'(i) < push_n_i) begin
        mem_q[tail_q + PW'(i)] <= push_toks_i[i];
      end
    end
  end

endmodule

### sim/att_checker.sv
// Transfer monitor, token predictor and scoreboard for the assembly text tokenizer.
`timescale 1ns / 100ps

module att_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  att_pkg::att_item_t  in_data_i,
  input  logic                in_stall_i,
  input  logic                out_valid_i,
  input  att_pkg::att_token_t out_data_i,
  input  logic                out_stall_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import att_pkg::*;

  typedef enum logic [4:0] {
    LX_WS, LX_SLASH, LX_LINE, LX_BLK, LX_BLKSTAR, LX_MINUS, LX_ZERO, LX_INT,
    LX_FRAC, LX_EXP0, LX_EXPD, LX_HEX, LX_TAIL, LX_IDENT, LX_COLON1, LX_COLON2,
    LX_PCT, LX_PCTPCT, LX_PCTNUM, LX_PCTREG, LX_DOL, LX_DOLNUM
  } lex_mode_e;

  localparam logic [16:0] SRC_LIMIT = 17'(MAX_SOURCE_BYTES);

  // Predictor state
  lex_mode_e   mode;
  logic [16:0] origin;
  logic [16:0] bpos;
  logic [15:0] held;
  logic [1:0]  hcnt;
  logic        hex_tok;
  logic        tail_letters;
  logic        halted;

  att_token_t  run_tok [MAX_RESULTS];
  int          run_cnt;
  att_token_t  token_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = token_q.size();

  function automatic logic c_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic c_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic c_cont(logic [7:0] c);
    return c_start(c) || c_dec(c);
  endfunction
  function automatic logic c_hex(logic [7:0] c);
    return c_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic c_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction
  function automatic int punct_of(logic [7:0] c);
    case (c)
      ".": return KIND_DOT;
      ",": return KIND_COMMA;
      ";": return KIND_SEMI;
      "[": return KIND_LBRACK;
      "]": return KIND_RBRACK;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      "+": return KIND_PLUS;
      "@": return KIND_AT;
      "!": return KIND_BANG;
      default: return -1;
    endcase
  endfunction
  function automatic logic [15:0] sat16(logic [16:0] v);
    return v > 17'd65535 ? 16'hFFFF : v[15:0];
  endfunction

  task automatic clear_lexer();
    mode = LX_WS; origin = '0; bpos = '0; held = '0; hcnt = '0;
    hex_tok = 0; tail_letters = 0; halted = 0;
  endtask

  task automatic put_tok(logic [4:0] kind, logic [16:0] s, logic [16:0] e);
    att_token_t t;
    if (run_cnt < MAX_RESULTS) begin
      t.token_kind   = kind;
      t.token_start  = sat16(s);
      t.token_length = sat16(e >= s ? e - s : 17'd0);
      t.last_of_run  = 1'b0;
      run_tok[run_cnt] = t;
      run_cnt++;
    end
  endtask

  task automatic flag_error(logic [16:0] at);
    put_tok(KIND_ERROR, at, at + 1);
    halted = 1; origin = at + 1; mode = LX_WS; hcnt = '0;
  endtask

  task automatic close_number(logic [16:0] e);
    put_tok((tail_letters && !hex_tok) ? KIND_IDENT : KIND_NUMBER, origin, e);
  endtask

  task automatic bad_colon(logic [16:0] p);
    logic [16:0] cp;
    cp = p - hcnt;
    put_tok(KIND_IDENT, origin, cp);
    flag_error(cp);
  endtask

  task automatic begin_token(logic [7:0] c, logic [16:0] p);
    int pk;
    pk = punct_of(c);
    origin = p; hex_tok = 0; tail_letters = 0; hcnt = '0;
    if (c_space(c)) return;
    if (pk >= 0) begin
      put_tok(5'(pk), p, p + 1);
    end else if (c == CH_SLASH) begin
      mode = LX_SLASH; held = {8'h0, c}; hcnt = 1;
    end else if (c == CH_MINUS) begin
      mode = LX_MINUS; held = {8'h0, c}; hcnt = 1;
    end else if (c_dec(c)) begin
      mode = (c == CH_ZERO) ? LX_ZERO : LX_INT;
    end else if (c_start(c)) begin
      mode = LX_IDENT;
    end else if (c == CH_PERCENT) begin
      mode = LX_PCT;
    end else if (c == CH_DOLLAR) begin
      mode = LX_DOL;
    end else begin
      flag_error(p);
    end
  endtask

  // One byte through the lexer; a token ending before c hands c back to the loop
  task automatic lex_char(logic [7:0] c, logic [16:0] p);
    logic again;
    again = 1;
    while (again) begin
      again = 0;
      case (mode)
        LX_WS: begin_token(c, p);
        LX_SLASH: begin
          hcnt = 0;
          if (c == CH_SLASH) mode = LX_LINE;
          else if (c == CH_STAR) mode = LX_BLK;
          else flag_error(origin);
        end
        LX_LINE: if (c == CH_NL) mode = LX_WS;
        LX_BLK, LX_BLKSTAR: begin
          if (mode == LX_BLKSTAR && c == CH_SLASH) begin
            mode = LX_WS; hcnt = 0;
          end else begin
            mode = (c == CH_STAR) ? LX_BLKSTAR : LX_BLK;
            held = {8'h0, c}; hcnt = 1;
          end
        end
        LX_MINUS: begin
          hcnt = 0;
          if (c_dec(c)) mode = (c == CH_ZERO) ? LX_ZERO : LX_INT;
          else begin
            put_tok(KIND_MINUS, origin, origin + 1);
            mode = LX_WS; again = 1;
          end
        end
        LX_ZERO: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            hex_tok = 1; mode = LX_HEX;
          end else begin
            mode = LX_INT; again = 1;
          end
        end
        LX_INT: begin
          if (c_dec(c)) ;
          else if (c == CH_DOT) mode = LX_FRAC;
          else if (c == CH_LOW_E || c == CH_UP_E) mode = LX_EXP0;
          else begin mode = LX_TAIL; again = 1; end
        end
        LX_FRAC: begin
          if (c_dec(c)) ;
          else if (c == CH_LOW_E || c == CH_UP_E) mode = LX_EXP0;
          else begin mode = LX_TAIL; again = 1; end
        end
        LX_EXP0: begin
          if (c == CH_PLUS || c == CH_MINUS || c_dec(c)) mode = LX_EXPD;
          else begin mode = LX_TAIL; again = 1; end
        end
        LX_EXPD: if (!c_dec(c)) begin mode = LX_TAIL; again = 1; end
        LX_HEX:  if (!c_hex(c)) begin mode = LX_TAIL; again = 1; end
        LX_TAIL: begin
          if (c_cont(c)) tail_letters = 1;
          else begin
            close_number(p); mode = LX_WS; again = 1;
          end
        end
        LX_IDENT: begin
          if (c_cont(c)) ;
          else if (c == CH_COLON) begin
            mode = LX_COLON1; held = {8'h0, c}; hcnt = 1;
          end else begin
            put_tok(KIND_IDENT, origin, p); mode = LX_WS; again = 1;
          end
        end
        LX_COLON1: begin
          if (c == CH_COLON) begin
            mode = LX_COLON2; held = {held[7:0], c}; hcnt = 2;
          end else bad_colon(p);
        end
        LX_COLON2: begin
          if (c_cont(c)) begin mode = LX_IDENT; hcnt = 0; end
          else bad_colon(p);
        end
        LX_PCT: begin
          if (c == CH_PERCENT) mode = LX_PCTPCT;
          else if (c_dec(c)) mode = LX_PCTNUM;
          else if (c_start(c)) mode = LX_PCTREG;
          else flag_error(origin);
        end
        LX_PCTPCT, LX_PCTREG: begin
          if (c_cont(c) || (mode == LX_PCTPCT && c == CH_DOT)) ;
          else begin
            put_tok(KIND_REG, origin, p); mode = LX_WS; again = 1;
          end
        end
        LX_PCTNUM, LX_DOLNUM: begin
          if (!c_dec(c)) begin
            put_tok(KIND_OPREF, origin, p); mode = LX_WS; again = 1;
          end
        end
        LX_DOL: begin
          if (c_dec(c)) mode = LX_DOLNUM;
          else flag_error(origin);
        end
        default: begin mode = LX_WS; again = 1; end
      endcase
    end
  endtask

  // End of source: flush the open token, then the end-of-file token
  task automatic end_source();
    logic [16:0] p;
    logic        relex;
    p = bpos;
    if (!halted && (mode == LX_BLK || mode == LX_BLKSTAR)) begin
      relex = hcnt != 0;
      mode = LX_WS; hcnt = 0;
      if (relex) lex_char(held[7:0], p - 1);
    end
    if (!halted) begin
      case (mode)
        LX_SLASH, LX_PCT, LX_DOL: flag_error(origin);
        LX_MINUS: put_tok(KIND_MINUS, origin, origin + 1);
        LX_ZERO, LX_INT, LX_FRAC, LX_EXP0, LX_EXPD, LX_HEX, LX_TAIL: close_number(p);
        LX_IDENT: put_tok(KIND_IDENT, origin, p);
        LX_COLON1, LX_COLON2: bad_colon(p);
        LX_PCTPCT, LX_PCTREG: put_tok(KIND_REG, origin, p);
        LX_PCTNUM, LX_DOLNUM: put_tok(KIND_OPREF, origin, p);
        default: ;
      endcase
    end
    if (halted) put_tok(KIND_EOF, origin, origin);
    else put_tok(KIND_EOF, p, p);
  endtask

  task automatic predict_item(att_item_t it);
    run_cnt = 0;
    if (!it.no_char && !halted && bpos < SRC_LIMIT) begin
      lex_char(it.ch, bpos);
      bpos++;
    end
    if (it.final_item) begin
      end_source();
      clear_lexer();
    end
    if (run_cnt > 0) run_tok[run_cnt-1].last_of_run = 1'b1;
    for (int i = 0; i < run_cnt; i++) token_q = {token_q, run_tok[i]};
  endtask

  // Watch both channels; predictions go first, tokens never leave in the cycle they start
  always @(posedge clk_i or negedge rst_ni) begin
    att_token_t want;
    if (!rst_ni) begin
      clear_lexer();
      token_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected token kind=%0d start=%0d len=%0d last=%0b", $time,
                   out_data_i.token_kind, out_data_i.token_start,
                   out_data_i.token_length, out_data_i.last_of_run);
        end else begin
          want = token_q.pop_front();
          if (out_data_i !== want) begin
            fails++;
            $display("%0t: token mismatch expected kind=%0d start=%0d len=%0d last=%0b",
                     $time, want.token_kind, want.token_start, want.token_length,
                     want.last_of_run);
            $display("%0t:                  actual kind=%0d start=%0d len=%0d last=%0b",
                     $time, out_data_i.token_kind, out_data_i.token_start,
                     out_data_i.token_length, out_data_i.last_of_run);
          end
        end
      end
    end
  end

endmodule

### sim/tb_assembly_text_tokenizer.sv
// Testbench top for the assembly text tokenizer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_assembly_text_tokenizer;
  import att_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  att_item_t  in_data_i = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  att_token_t out_data_o;
  logic       out_stall_i = 0;
  int         fail_count;
  int         pending;
  int         sent;

  assembly_text_tokenizer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .out_valid_o, .out_data_o, .out_stall_i
  );

  att_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_i(in_stall_o),
    .out_valid_i(out_valid_o), .out_data_i(out_data_o), .out_stall_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Receiver back-pressure: runs of open and stalled cycles, mostly short
  int stall_left = 0;
  always @(posedge clk_i) begin
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 0; stall_left <= $urandom_range(0, 15);
      end else if (r < 93) begin
        out_stall_i <= 1; stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1; stall_left <= $urandom_range(15, 40);
      end
    end
  end

  // One item, held until accepted, then an optional random gap
  task automatic send_item(logic [7:0] c, logic fin, logic none);
    int r;
    int gap;
    in_valid_i <= 1;
    in_data_i  <= '{ch: c, final_item: fin, no_char: none};
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s, bit term);
    for (int i = 0; i < s.len(); i++) send_item(s[i], term && i == s.len() - 1, 0);
  endtask

  string frags [] = '{"mov", "ld.global", "a::b", "ns::x1", "_q9", "%r12", "%%ctaid.x",
                      "%7", "$3", "0", "42", "-17", "0x1fA", "3.25", "1e5", "2.5E-3",
                      "7e+2", "12ab", "0xffzz", ",", ".", ";", "[", "]", "{", "}", "+",
                      "@", "!", "-", "// note\n", "/* c */", "/**/", "\n", " ", "\t"};
  string seps [] = '{" ", "", ", ", "\n", "\t", " // x\n", "/*y*/"};

  initial begin
    string s;
    int r;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed sources
    send_text("ld %r1,[$2];", 1);
    send_text("0x1F -7 1.5e-3 42ab", 1);
    send_text("a::b a:b", 1);
    send_text("c::1", 1);
    send_text("%%t.x %3 % q", 1);
    send_text("$ /", 1);
    send_text("/*xy", 1);
    send_item(8'h00, 0, 0);
    send_item(8'hFF, 1, 0);
    send_item(8'h41, 0, 1);
    send_item(8'h00, 1, 1);
    send_text("@!{}+.-", 1);

    // Let everything drain once before the random part
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);

    // Random sources: mostly well-formed text, some raw noise
    while (sent < 180) begin
      s = "";
      repeat ($urandom_range(1, 5)) begin
        r = $urandom_range(0, 99);
        if (r < 85) s = {s, frags[$urandom_range(0, frags.size() - 1)],
                         seps[$urandom_range(0, seps.size() - 1)]};
        else s = {s, string'(8'($urandom_range(0, 255)))};
      end
      if (s.len() == 0) s = " ";
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_text(s, 0);
        send_item(8'($urandom_range(0, 255)), 1, 1);
      end else begin
        send_text(s, 1);
      end
    end

    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("assembly_text_tokenizer regression: pass");
    end else begin
      $display("assembly_text_tokenizer regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("assembly_text_tokenizer regression: fail");
    $finish;
  end

endmodule

### assembly_text_tokenizer.f
rtl/att_pkg.sv
rtl/att_front.sv
rtl/att_lexer.sv
rtl/att_tok_fifo.sv
rtl/assembly_text_tokenizer.sv
sim/att_checker.sv
sim/tb_assembly_text_tokenizer.sv
